[hdl/assert_macros.svh]
// Assertion macros for the block's checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the next cycle, masked while reset is asserted.
`define LBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Same-cycle implication, masked while reset is asserted.
`define LBB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked through reset.
`define LBB_ASSERT_NEXT_NR(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/lbb_pkg.sv]
// Shared constants and types for the line box blur pass.
package lbb_pkg;

    localparam int DEF_MAX_RADIUS  = 30;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int RADIUS_W   = 5;
    localparam int COEF_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_RADIUS = 2'd0;
    localparam t_cfg_idx CFG_RECIP  = 2'd1;
    localparam t_cfg_idx CFG_GAIN   = 2'd2;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 5'd1;
    localparam logic [COEF_W-1:0]   RECIP_RST  = 16'd21845;
    localparam logic [COEF_W-1:0]   GAIN_RST   = 16'd4096;

endpackage

[hdl/line_box_blur_pass.sv]
// Line box blur pass: one-dimensional running-sum box blur over a line of alpha samples.
//
// Samples of one line come in on the input channel, one transaction each, with
// i_line_end_in set on the last one. For output index i the block forms the pair
// W(i) + W(i+1) of two centered box sums of 2*radius+1 samples (samples outside
// the line are zero), scales it by recip_window and one half with round-half-up,
// then by out_gain (Q4.12) with round-half-up, and saturates to SAMPLE_BITS.
// Output i appears after sample i+radius+1 has been taken; the line-end sample
// pushes radius+1 zero samples internally, emits the remaining outputs (the last
// one carries o_line_end_out) and clears the line state. Work is done by one
// sequencer around a single shared multiplier and one sample RAM of
// 2*MAX_RADIUS+2 entries (one write and one read port, registered read), so the
// block takes one input transaction at a time. Each input transaction runs a RAM
// read, an update and a step decision; when an output falls due, two passes
// through the multiplier and an output load come between update and decision. A
// change of radius since the last sample of the current line first rebuilds the
// window sum from the RAM; a line-end sample adds radius+1 further pushes through
// the same steps. The sequencer waits in the output load while the output
// register is held by i_out_stall. Line history lives in the RAM behind a fill
// count, so no clearing pass is needed after reset or between lines.
// Configuration writes are taken at any time but are meant for idle periods:
// index 0 radius (0 acts as 1, above MAX_RADIUS acts as MAX_RADIUS),
// index 1 recip_window, index 2 out_gain; other indexes are ignored.
module line_box_blur_pass #(
    parameter int MAX_RADIUS  = lbb_pkg::DEF_MAX_RADIUS,
    parameter int SAMPLE_BITS = lbb_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [lbb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lbb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // sample input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [SAMPLE_BITS-1:0]        i_alpha_in,
    input  logic                          i_line_end_in,
    // result output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [SAMPLE_BITS-1:0]        o_alpha_out,
    output logic                          o_line_end_out
);

    localparam int DEPTH      = 2 * MAX_RADIUS + 2;         // delay line length
    localparam int AW         = $clog2(DEPTH);              // RAM address
    localparam int CW         = $clog2(DEPTH + 1);          // fill count
    localparam int RW         = $clog2(MAX_RADIUS + 1);     // effective radius
    localparam int FW         = $clog2(MAX_RADIUS + 2);     // flush pushes left
    localparam int SUM_W      = SAMPLE_BITS + $clog2(DEPTH);
    localparam int PAIR_W     = SUM_W + 1;
    localparam int COEF_W     = lbb_pkg::COEF_W;
    localparam int PROD_W     = PAIR_W + COEF_W;
    localparam int BLUR_SHIFT = COEF_W + 1;                 // Q0.16 recip plus the half
    localparam int BLUR_W     = PROD_W - BLUR_SHIFT;
    localparam int GAIN_FRAC  = 12;                         // Q4.12 gain
    localparam int RES_W      = PROD_W - GAIN_FRAC;

    localparam logic [PROD_W-1:0]      BLUR_RND = PROD_W'(1) << (BLUR_SHIFT - 1);
    localparam logic [PROD_W-1:0]      GAIN_RND = PROD_W'(1) << (GAIN_FRAC - 1);
    localparam logic [SAMPLE_BITS-1:0] SAT_MAX  = {SAMPLE_BITS{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,     // ready for a sample
        S_RESUM,    // rebuild window sum for a new radius
        S_READ,     // fetch the sample that leaves the window
        S_PUSH,     // write sample, update running sum
        S_MUL1,     // pair * recip
        S_MUL2,     // blur * gain
        S_OUT,      // round, saturate, load output register
        S_NEXT      // start or continue flush, finish line or go idle
    } t_state;

    // configuration registers
    logic [lbb_pkg::RADIUS_W-1:0] r_radius;
    logic [COEF_W-1:0]            r_recip;
    logic [COEF_W-1:0]            r_gain;

    // sequencer and datapath registers
    t_state                  r_state,        n_state;
    logic [AW-1:0]           r_wp,           n_wp;
    logic [CW-1:0]           r_pos,          n_pos;
    logic [SUM_W-1:0]        r_sum,          n_sum;
    logic [RW-1:0]           r_sum_rad,      n_sum_rad;
    logic [SAMPLE_BITS-1:0]  r_x,            n_x;
    logic                    r_last,         n_last;
    logic                    r_flushing,     n_flushing;
    logic [FW-1:0]           r_left,         n_left;
    logic [CW-1:0]           r_k,            n_k;
    logic                    r_rd_pend,      n_rd_pend;
    logic                    r_rd_mask,      n_rd_mask;
    logic [PAIR_W-1:0]       r_pair,         n_pair;
    logic [PROD_W-1:0]       r_prod,         n_prod;
    logic                    r_tag,          n_tag;
    logic                    r_out_valid,    n_out_valid;
    logic [SAMPLE_BITS-1:0]  r_alpha_out,    n_alpha_out;
    logic                    r_line_end_out, n_line_end_out;

    // combinational helpers
    logic [RW-1:0]          eff_r;
    logic [CW-1:0]          two_r;
    logic [CW-1:0]          rd_k;
    logic [CW:0]            addr_t;
    logic [AW-1:0]          rd_addr;
    logic [SAMPLE_BITS-1:0] ram_q;
    logic                   ram_we;
    logic [SUM_W-1:0]       leave_val;
    logic [SUM_W-1:0]       newer;
    logic [AW-1:0]          wp_inc;
    logic [CW-1:0]          pos_inc;
    logic                   out_due;
    logic [PAIR_W-1:0]      mul_a;
    logic [COEF_W-1:0]      mul_b;
    logic [PROD_W-1:0]      mul_p;
    logic [PROD_W-1:0]      blur_t;
    logic [BLUR_W-1:0]      blur;
    logic [PROD_W-1:0]      res_t;
    logic [RES_W-1:0]       res;
    logic [SAMPLE_BITS-1:0] res_sat;
    logic                   in_acc;
    logic                   out_load;

    // ---------------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= lbb_pkg::RADIUS_RST;
            r_recip  <= lbb_pkg::RECIP_RST;
            r_gain   <= lbb_pkg::GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lbb_pkg::CFG_RADIUS: r_radius <= i_cfg_data[lbb_pkg::RADIUS_W-1:0];
                lbb_pkg::CFG_RECIP:  r_recip  <= i_cfg_data[COEF_W-1:0];
                lbb_pkg::CFG_GAIN:   r_gain   <= i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp radius into 1..MAX_RADIUS.
    always_comb begin
        if (r_radius == '0) begin
            eff_r = RW'(1);
        end else if (int'(r_radius) > MAX_RADIUS) begin
            eff_r = RW'(MAX_RADIUS);
        end else begin
            eff_r = RW'(r_radius);
        end
    end

    assign two_r = CW'({eff_r, 1'b0});

    // ---------------------------------------------------------------------
    // Sample history: circular buffer, entry k (0 = newest) sits at wp-1-k.
    // Entries at or beyond the fill count read as zero.
    // ---------------------------------------------------------------------
    assign rd_k    = (r_state == S_READ) ? two_r : r_k;
    assign addr_t  = (CW+1)'(r_wp) + (CW+1)'(DEPTH - 1) - (CW+1)'(rd_k);
    assign rd_addr = (addr_t >= (CW+1)'(DEPTH)) ? AW'(addr_t - (CW+1)'(DEPTH))
                                               : AW'(addr_t);
    assign ram_we  = (r_state == S_PUSH);

    lbb_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (r_x),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    assign leave_val = r_rd_mask ? SUM_W'(ram_q) : '0;
    // New window = old window + incoming sample - sample that drops out.
    assign newer     = r_sum + SUM_W'(r_x) - leave_val;
    assign wp_inc    = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
    assign pos_inc   = (r_pos == CW'(DEPTH)) ? r_pos : r_pos + CW'(1);
    assign out_due   = (CW+1)'(pos_inc) >= ((CW+1)'(eff_r) + (CW+1)'(2));

    // ---------------------------------------------------------------------
    // Shared multiplier: pair*recip first, then blur*gain.
    // ---------------------------------------------------------------------
    assign blur_t = (r_prod + BLUR_RND) >> BLUR_SHIFT;
    assign blur   = BLUR_W'(blur_t);
    assign mul_a  = (r_state == S_MUL2) ? PAIR_W'(blur) : r_pair;
    assign mul_b  = (r_state == S_MUL2) ? r_gain : r_recip;
    assign mul_p  = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign res_t   = (r_prod + GAIN_RND) >> GAIN_FRAC;
    assign res     = RES_W'(res_t);
    assign res_sat = (res > RES_W'(SAT_MAX)) ? SAT_MAX : SAMPLE_BITS'(res);

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        n_state        = r_state;
        n_wp           = r_wp;
        n_pos          = r_pos;
        n_sum          = r_sum;
        n_sum_rad      = r_sum_rad;
        n_x            = r_x;
        n_last         = r_last;
        n_flushing     = r_flushing;
        n_left         = r_left;
        n_k            = r_k;
        n_rd_pend      = r_rd_pend;
        n_rd_mask      = r_rd_mask;
        n_pair         = r_pair;
        n_prod         = r_prod;
        n_tag          = r_tag;
        n_out_valid    = r_out_valid;
        n_alpha_out    = r_alpha_out;
        n_line_end_out = r_line_end_out;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_x    = i_alpha_in;
                    n_last = i_line_end_in;
                    // Running sum only matches the radius it was built with;
                    // an empty line has a zero sum for any radius.
                    if ((r_pos != '0) && (eff_r != r_sum_rad)) begin
                        n_state   = S_RESUM;
                        n_k       = '0;
                        n_sum     = '0;
                        n_rd_pend = 1'b0;
                    end else begin
                        n_sum_rad = eff_r;
                        n_state   = S_READ;
                    end
                end
            end
            S_RESUM: begin
                // one read issued and one accumulated per cycle
                if (r_rd_pend) begin
                    n_sum = r_sum + leave_val;
                end
                if (r_k <= two_r) begin
                    n_k       = r_k + CW'(1);
                    n_rd_pend = 1'b1;
                    n_rd_mask = (r_k < r_pos);
                end else begin
                    n_rd_pend = 1'b0;
                    n_sum_rad = eff_r;
                    n_state   = S_READ;
                end
            end
            S_READ: begin
                n_rd_mask = (two_r < r_pos);
                n_state   = S_PUSH;
            end
            S_PUSH: begin
                n_wp  = wp_inc;
                n_pos = pos_inc;
                n_sum = newer;
                n_tag = r_flushing && (r_left == FW'(1));
                if (r_flushing) begin
                    n_left = r_left - FW'(1);
                end
                if (out_due) begin
                    n_pair  = PAIR_W'(newer) + PAIR_W'(r_sum);
                    n_state = S_MUL1;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_MUL1: begin
                n_prod  = mul_p;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_prod  = mul_p;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_out_valid    = 1'b1;
                    n_alpha_out    = res_sat;
                    n_line_end_out = r_tag;
                    n_state        = S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_flushing) begin
                    if (r_left != '0) begin
                        n_x     = '0;
                        n_state = S_READ;
                    end else begin
                        // line done: empty the history
                        n_flushing = 1'b0;
                        n_pos      = '0;
                        n_sum      = '0;
                        n_state    = S_IDLE;
                    end
                end else if (r_last) begin
                    // line end: push radius+1 zero samples
                    n_flushing = 1'b1;
                    n_last     = 1'b0;
                    n_left     = FW'(eff_r) + FW'(1);
                    n_x        = '0;
                    n_state    = S_READ;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_pos       <= '0;
            r_sum       <= '0;
            r_sum_rad   <= RW'(1);
            r_last      <= 1'b0;
            r_flushing  <= 1'b0;
            r_left      <= '0;
            r_k         <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_pos       <= n_pos;
            r_sum       <= n_sum;
            r_sum_rad   <= n_sum_rad;
            r_last      <= n_last;
            r_flushing  <= n_flushing;
            r_left      <= n_left;
            r_k         <= n_k;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
        r_x            <= n_x;
        r_rd_mask      <= n_rd_mask;
        r_pair         <= n_pair;
        r_prod         <= n_prod;
        r_tag          <= n_tag;
        r_alpha_out    <= n_alpha_out;
        r_line_end_out <= n_line_end_out;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_alpha_out    = r_alpha_out;
    assign o_line_end_out = r_line_end_out;

endmodule

[hdl/lbb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lbb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 62
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/lbb_checker.sv]
// Port-level checker for the line box blur pass, bound to the top level.
`include "assert_macros.svh"

module lbb_checker #(
    parameter int SAMPLE_BITS = lbb_pkg::DEF_SAMPLE_BITS
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [SAMPLE_BITS-1:0] o_alpha_out,
    input logic                   o_line_end_out
);

    // a held result keeps its payload
    `LBB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_alpha_out) && $stable(o_line_end_out))

    // reset empties the output register
    `LBB_ASSERT_NEXT_NR(a_rst_out, i_clk, !i_rst_n, !o_out_valid)

    // one sample in flight: busy right after a transaction
    `LBB_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // results only come out of work on a sample
    `LBB_ASSERT_NOW(a_out_while_busy, i_clk, i_rst_n, $rose(o_out_valid), o_in_stall)

endmodule

bind line_box_blur_pass lbb_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_lbb_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for the line box blur pass: directed and random lines.
`timescale 1ns / 1ps

module testbench;

    localparam int SB          = lbb_pkg::DEF_SAMPLE_BITS;
    localparam int MAXR        = lbb_pkg::DEF_MAX_RADIUS;
    localparam int HIST_DEPTH  = 2 * MAXR + 2;
    // Longest the block stays busy with no result left to deliver: a sample
    // that makes no output at radius 30 after a window rebuild; the value is
    // rounded well up.
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 17;
    localparam int PHASES        = 8;

    typedef struct packed {
        logic [SB-1:0] alpha;
        logic          line_end;
    } t_blur_result;

    // Behavioral blur of one line: keeps its own sample history and
    // register copies, and queues the outputs each sample makes due.
    class blur_scoreboard;
        logic [SB-1:0] hist [HIST_DEPTH];    // newest first
        int unsigned   fill;                 // samples taken in this line, saturating
        logic [lbb_pkg::RADIUS_W-1:0] radius_reg;
        logic [lbb_pkg::COEF_W-1:0]   recip_reg;
        logic [lbb_pkg::COEF_W-1:0]   gain_reg;
        t_blur_result  expected_q [$];
        int unsigned   errors;

        function new();
            foreach (hist[k]) hist[k] = '0;
            fill       = 0;
            radius_reg = lbb_pkg::RADIUS_RST;
            recip_reg  = lbb_pkg::RECIP_RST;
            gain_reg   = lbb_pkg::GAIN_RST;
            errors     = 0;
        endfunction

        function void set_config(logic [lbb_pkg::RADIUS_W-1:0] r,
                                 logic [lbb_pkg::COEF_W-1:0] rc,
                                 logic [lbb_pkg::COEF_W-1:0] g);
            radius_reg = r;
            recip_reg  = rc;
            gain_reg   = g;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Sum of 2r+1 history entries from offset off; past the end counts as zero.
        function longint unsigned window_total(int unsigned off, int unsigned r);
            longint unsigned s;
            s = 0;
            for (int unsigned k = 0; k <= 2 * r; k++) begin
                if (off + k < HIST_DEPTH) s += hist[off + k];
            end
            return s;
        endfunction

        function void shift_in(logic [SB-1:0] x, int unsigned r, inout int unsigned n);
            longint unsigned pair;
            longint unsigned blur;
            longint unsigned res;
            t_blur_result    item;
            for (int k = HIST_DEPTH - 1; k > 0; k--) hist[k] = hist[k - 1];
            hist[0] = x;
            if (fill < HIST_DEPTH) fill++;
            if (fill < r + 2) return;
            pair = window_total(0, r) + window_total(1, r);
            // pair * recip / 2, round half up; then Q4.12 gain, round half up
            blur = (pair * recip_reg + 64'd65536) >> 17;
            res  = (blur * gain_reg + 64'd2048) >> 12;
            if (res > (64'd1 << SB) - 1) res = (64'd1 << SB) - 1;
            item.alpha    = res[SB-1:0];
            item.line_end = 1'b0;
            expected_q.push_back(item);
            n++;
        endfunction

        function void note_sample(logic [SB-1:0] alpha, logic line_end);
            int unsigned  r;
            int unsigned  n;
            t_blur_result tail;
            // radius 0 behaves as 1, anything above MAXR as MAXR
            r = (radius_reg == 0) ? 1 : ((radius_reg > MAXR) ? MAXR : radius_reg);
            n = 0;
            shift_in(alpha, r, n);
            if (!line_end) return;
            // flush: r+1 zero samples close the line
            for (int unsigned j = 0; j <= r; j++) begin
                if (n < 32) shift_in('0, r, n);
            end
            if (n > 0) begin
                tail = expected_q.pop_back();
                tail.line_end = 1'b1;
                expected_q.push_back(tail);
            end
            foreach (hist[k]) hist[k] = '0;
            fill = 0;
        endfunction

        function void flag(string what, t_blur_result want, t_blur_result got);
            errors++;
            if (errors <= 10)
                $display("%0t: %s: expected alpha %0d end %0b, got alpha %0d end %0b",
                         $realtime, what, want.alpha, want.line_end,
                         got.alpha, got.line_end);
        endfunction

        function void check_result(logic [SB-1:0] alpha, logic line_end);
            t_blur_result want;
            t_blur_result got;
            got.alpha    = alpha;
            got.line_end = line_end;
            if (expected_q.size() == 0) begin
                flag("result with nothing outstanding", '0, got);
                return;
            end
            want = expected_q.pop_front();
            if (want.alpha !== got.alpha || want.line_end !== got.line_end)
                flag("mismatch", want, got);
        endfunction
    endclass

    // DUT stimulus, all known from time zero
    logic             i_clk;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    lbb_pkg::t_cfg_idx cfg_index = lbb_pkg::CFG_RADIUS;
    logic [lbb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic             in_valid  = 1'b0;
    logic [SB-1:0]    alpha_in  = '0;
    logic             line_end_in = 1'b0;
    logic             out_stall = 1'b0;

    logic             in_stall;
    logic             out_valid;
    logic [SB-1:0]    alpha_out;
    logic             line_end_out;

    // testbench control
    blur_scoreboard   sb;
    bit               idle_en  = 1'b1;   // random gaps and stalls allowed
    bit               hold_req = 1'b0;   // ask the receiver for one long hold-off
    int               line_left = 0;     // samples still to send in the open random line
    logic [SB-1:0]    next_alpha;
    logic [lbb_pkg::RADIUS_W-1:0] set_radius;
    logic [lbb_pkg::COEF_W-1:0]   set_recip;
    logic [lbb_pkg::COEF_W-1:0]   set_gain;
    int unsigned      eff_r;

    line_box_blur_pass u_top (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_alpha_in     (alpha_in),
        .i_line_end_in  (line_end_in),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_alpha_out    (alpha_out),
        .o_line_end_out (line_end_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle watchdog: a hung handshake ends the run here.
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Result monitor: every accepted output transaction is checked in order.
    always @(posedge i_clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(alpha_out, line_end_out);
    end

    // Receiver side. Random stall bursts while idling is on; one long hold
    // on request so that the block backs up and stalls its input.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one sample; returns on the falling edge after its transaction.
    // Valid is left high so back-to-back samples need no extra step.
    task automatic send_sample(logic [SB-1:0] alpha, logic line_end);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid    <= 1'b1;
        alpha_in    <= alpha;
        line_end_in <= line_end;
        do @(posedge i_clk); while (!(in_valid && !in_stall));
        sb.note_sample(alpha, line_end);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until all predicted outputs are in, then
    // let extra cycles pass for a sample that makes no output.
    task automatic settle(int extra);
        in_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
        repeat (extra) @(negedge i_clk);
    endtask

    // Write all three registers on consecutive cycles; block must be idle.
    task automatic apply_setting(logic [lbb_pkg::RADIUS_W-1:0] r,
                                 logic [lbb_pkg::COEF_W-1:0] rc,
                                 logic [lbb_pkg::COEF_W-1:0] g);
        cfg_we    <= 1'b1;
        cfg_index <= lbb_pkg::CFG_RADIUS;
        cfg_data  <= lbb_pkg::CFG_DATA_W'(r);
        @(negedge i_clk);
        cfg_index <= lbb_pkg::CFG_RECIP;
        cfg_data  <= rc;
        @(negedge i_clk);
        cfg_index <= lbb_pkg::CFG_GAIN;
        cfg_data  <= g;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        sb.set_config(r, rc, g);
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed part, reset register values first (radius 1, 1/3, unity)
        send_sample(16'hFFFF, 1'b1);                 // line of a single sample
        send_sample(16'h0000, 1'b0);                 // isolated peak
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b1);
        for (int i = 0; i < 4; i++) send_sample(16'hFFFF, i == 3);  // full scale
        for (int i = 0; i < 4; i++)                  // every bit both ways
            send_sample(i[0] ? 16'h5555 : 16'hAAAA, i == 3);

        // maximum gain: output saturates
        settle(SETTLE_CYCLES);
        apply_setting(5'd1, lbb_pkg::RECIP_RST, 16'hFFFF);
        for (int i = 0; i < 3; i++) send_sample(16'hFFFF, i == 2);

        // radius 0 behaves as 1; zero reciprocal blanks everything
        settle(SETTLE_CYCLES);
        apply_setting(5'd0, 16'h0000, lbb_pkg::GAIN_RST);
        send_sample(16'h1234, 1'b0);
        send_sample(16'hFFFF, 1'b1);

        // radius 31 clamps to 30; line left open so nothing is due yet
        settle(SETTLE_CYCLES);
        apply_setting(5'd31, 16'hFFFF, lbb_pkg::GAIN_RST);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0001, 1'b0);

        // radius shrinks in the middle of that line, history is reused
        settle(SETTLE_CYCLES);
        apply_setting(5'd2, 16'd13107, lbb_pkg::GAIN_RST);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b1);

        // ---- random part: phases of random lines under random settings.
        // A line may span a phase boundary, so radius changes mid-line too.
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph >= PHASES - 2) idle_en = 1'b0;   // no idling at the tail
            settle(SETTLE_CYCLES);
            case ($urandom_range(0, 9))
                0:       set_radius = 5'd0;
                1:       set_radius = 5'd31;
                2:       set_radius = 5'd30;
                3:       set_radius = 5'd1;
                default: set_radius = 5'($urandom_range(1, 8));
            endcase
            eff_r = (set_radius == 0) ? 1 : ((set_radius > MAXR) ? MAXR : set_radius);
            case ($urandom_range(0, 7))
                0:       set_recip = 16'h0000;
                1:       set_recip = 16'hFFFF;
                2:       set_recip = 16'($urandom_range(0, 65535));
                default: set_recip = 16'(65536 / (2 * eff_r + 1));
            endcase
            case ($urandom_range(0, 7))
                0:       set_gain = 16'h0000;
                1:       set_gain = 16'hFFFF;
                2:       set_gain = 16'($urandom_range(0, 65535));
                3:       set_gain = 16'($urandom_range(4096, 12288));
                default: set_gain = lbb_pkg::GAIN_RST;
            endcase
            apply_setting(set_radius, set_recip, set_gain);

            // receiver holds off while samples keep coming
            if (ph == 1) hold_req = 1'b1;

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // sender pause until the block has delivered everything
                if (ph == 3 && i == PHASE_ITEMS / 2) settle(0);
                if (line_left == 0) begin
                    case ($urandom_range(0, 7))
                        0:       line_left = 1;
                        1:       line_left = $urandom_range(60, 80);  // saturates fill
                        default: line_left = $urandom_range(2, 40);
                    endcase
                end
                line_left--;
                case ($urandom_range(0, 7))
                    0:       next_alpha = '0;
                    1:       next_alpha = '1;
                    2:       next_alpha = SB'($urandom_range(0, 255));
                    3:       next_alpha = SB'($urandom_range(65280, 65535));
                    default: next_alpha = SB'($urandom_range(0, 65535));
                endcase
                send_sample(next_alpha, line_left == 0);
            end
        end

        // ---- drain and decide
        settle(SETTLE_CYCLES);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
